// File: design/lrm_pkg.sv
package lrm_pkg;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_VOLUME = 2'd2;

  localparam logic [2:0] MODE_BYPASS = 3'd0;
  localparam logic [2:0] MODE_SQUARE = 3'd1;
  localparam logic [2:0] MODE_SAW    = 3'd2;
  localparam logic [2:0] MODE_RECT   = 3'd3;
  localparam logic [2:0] MODE_SINE   = 3'd4;

  localparam logic [2:0]  MODE_RESET   = MODE_BYPASS;
  localparam logic [31:0] STEP_RESET   = 32'd19478311;
  localparam logic [14:0] VOLUME_RESET = 15'd0;

  localparam int SAMPLE_W = 16;
  localparam int VOLUME_W = 15;
  localparam int WAVE_W   = 17;
  localparam int PROD1_W  = WAVE_W + SAMPLE_W;
  localparam int PROD2_W  = PROD1_W + VOLUME_W + 1;
  localparam int OUT_SHIFT = 30;

  // pi in Q30 and the Taylor series divisors (2k)(2k+1) for k = 1..8.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] phase_step;
    logic [14:0] volume;
  } lrm_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_MUL,
    ST_DONE
  } lrm_state_t;

  typedef struct packed {
    logic accept;
    logic wave;
    logic mul;
    logic load;
  } lrm_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } lrm_status_t;

  function automatic logic is_bypass(input logic [2:0] mode);
    return !(mode == MODE_SQUARE || mode == MODE_SAW ||
             mode == MODE_RECT || mode == MODE_SINE);
  endfunction

  // One quarter-wave sine entry, round(sin(x) * 32768) with x = (pi/2) * i / 2^tab_bits,
  // evaluated in Q30 with a nine-term Taylor series. Used at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned tab_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (PI_Q30 * 64'(i)) >> (tab_bits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[k];
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) begin
      sum = 64'sd32768;
    end
    return sum[15:0];
  endfunction

endpackage

// File: design/lrm_regs.sv
module lrm_regs
  import lrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lrm_cfg_t    cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_RESET;
      cfg.phase_step <= STEP_RESET;
      cfg.volume     <= VOLUME_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:   cfg.mode       <= pwdata[2:0];
        REG_STEP:   cfg.phase_step <= pwdata;
        REG_VOLUME: cfg.volume     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = {29'd0, cfg.mode};
      REG_STEP:   prdata = cfg.phase_step;
      REG_VOLUME: prdata = {17'd0, cfg.volume};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// File: design/lrm_ctrl.sv
module lrm_ctrl
  import lrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  lrm_status_t status,
  output lrm_cmd_t    cmd
);

  lrm_state_t state;
  lrm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = status.bypass ? ST_DONE : ST_WAVE;
        end
      end
      ST_WAVE: begin
        cmd.wave   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Waits here only while the previous result is still unclaimed.
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/lrm_dpath.sv
module lrm_dpath
  import lrm_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lrm_cfg_t                   cfg,
  input  lrm_cmd_t                   cmd,
  output lrm_status_t                status,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int TAB_N     = 1 << SINE_TABLE_BITS;
  localparam int TAB_DEPTH = TAB_N + 1;
  localparam int ADDR_W    = SINE_TABLE_BITS + 1;

  typedef logic [15:0] sine_rom_t [TAB_DEPTH];

  function automatic sine_rom_t build_rom();
    sine_rom_t rom;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      rom[i] = sine_entry(i, SINE_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  logic [PHASE_BITS-1:0]         phase_acc;
  logic [SINE_TABLE_BITS+1:0]    phase_top;
  logic [1:0]                    quad;
  logic [SINE_TABLE_BITS-1:0]    idx;
  logic [ADDR_W-1:0]             rom_addr;
  logic [15:0]                   rom_q;
  logic signed [WAVE_W-1:0]      sine_val;
  logic signed [WAVE_W-1:0]      wave;
  logic signed [SAMPLE_W-1:0]    sample_reg;
  logic                          bypass_reg;
  logic signed [PROD1_W-1:0]     prod1;
  logic signed [PROD2_W-1:0]     prod2;
  logic signed [PROD2_W:0]       rounded;
  logic signed [PROD2_W-OUT_SHIFT:0] scaled;
  logic signed [SAMPLE_W-1:0]    sat_val;

  assign phase_top = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS + 2];
  assign quad      = phase_top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
  assign idx       = phase_top[SINE_TABLE_BITS-1:0];
  // The second and fourth quadrants read the table mirrored.
  assign rom_addr  = quad[0] ? ADDR_W'(TAB_N) - {1'b0, idx} : {1'b0, idx};

  // The phase does not move between the accept and the wave step, so the
  // registered table read lines up with the wave step.
  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  assign sine_val = quad[1] ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_comb begin
    unique case (cfg.mode)
      MODE_SQUARE: begin
        if (!phase_acc[PHASE_BITS-1] && phase_acc != '0) begin
          wave = 17'sd32768;
        end else begin
          wave = -17'sd32768;
        end
      end
      MODE_SAW:  wave = $signed({2'b00, phase_acc[PHASE_BITS-1 -: 15]});
      MODE_RECT: wave = sine_val[WAVE_W-1] ? -sine_val : sine_val;
      default:   wave = sine_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (cmd.wave) begin
      phase_acc <= phase_acc + PHASE_BITS'(cfg.phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_reg <= sample_in;
      bypass_reg <= is_bypass(cfg.mode);
    end
    if (cmd.wave) begin
      prod1 <= wave * sample_reg;
    end
    if (cmd.mul) begin
      prod2 <= prod1 * $signed({1'b0, cfg.volume});
    end
  end

  // Round half up, then clamp to the 16-bit range.
  assign rounded = PROD2_W'(prod2) + (PROD2_W + 1)'(64'sd1 <<< (OUT_SHIFT - 1));
  assign scaled  = rounded[PROD2_W:OUT_SHIFT];

  always_comb begin
    if (scaled > 32767) begin
      sat_val = 16'sh7fff;
    end else if (scaled < -32768) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_out <= bypass_reg ? sample_reg : sat_val;
    end
  end

  assign status.bypass   = is_bypass(cfg.mode);
  assign status.out_free = !out_valid || out_ready;

endmodule

// File: design/lfo_ring_modulator_top.sv
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata[15:0] = sample_in (signed)
// m_axis    out        m_tvalid/m_tready  m_tdata[15:0] = sample_out (signed)
// apb       in         psel/penable       mode @0x0, phase_step @0x4, volume @0x8
//
// A modulated sample passes through the steps accept, wave times sample,
// times volume, then round, saturate and load into the output register;
// the two multiply stages lie between accept and load. A bypassed sample goes
// straight from accept to load. Reset clears the phase and loads the
// register defaults. A result waiting in the output register does not block
// the next accept; that item only stalls at its final step until it is free.
module lfo_ring_modulator_top
  import lrm_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lrm_cfg_t    cfg;
  lrm_cmd_t    cmd;
  lrm_status_t status;
  logic signed [SAMPLE_W-1:0] sample_out;

  lrm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lrm_dpath #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .sample_in  ($signed(s_tdata)),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sample_out (sample_out)
  );

  assign m_tdata = sample_out;

endmodule
